// File: sv/asemops_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package asemops_pkg;

    localparam int NUM_SEMS_DEF = 32;
    localparam int MAX_OPS_DEF  = 32;

    localparam int KIND_W   = 2;
    localparam int IDX_IN_W = 6;
    localparam int VAL_W    = 16;
    localparam int ST_W     = 3;
    localparam int CNT_W    = 6;
    localparam int CFG_W    = 6;

    localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

    localparam logic [KIND_W-1:0] KIND_OP  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SET = 2'd1;
    localparam logic [KIND_W-1:0] KIND_GET = 2'd2;

    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_BLOCK   = 3'd1;
    localparam logic [ST_W-1:0] ST_AGAIN   = 3'd2;
    localparam logic [ST_W-1:0] ST_BADIDX  = 3'd3;
    localparam logic [ST_W-1:0] ST_TOOMANY = 3'd4;

    typedef struct packed {
        logic capture;
        logic step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic has_result;
    } dp_sts_t;

endpackage

`default_nettype wire

// File: sv/atomic_semaphore_set_ops.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Dir | Handshake             | Payload
// in      | in  | in_valid / in_ready   | kind, sem_index, sem_delta, no_wait, last_op,
//         |     |                       | new_value
// out     | out | out_valid / out_ready | status, read_value
// cfg     | in  | cfg_wr_en             | cfg_wr_data (sems_in_use)
//
// Each beat is read and then executed: capture reads both copies of the addressed
// semaphore from the bank memories, execute updates and posts the result.
// An item whose result finds the output slot full waits in execute; a beat
// can still be accepted while a finished result waits to be taken.
// Reset clears the bank (valid bits), transaction state and sems_in_use to 32.
// No clearing pass after reset.

module atomic_semaphore_set_ops
    import asemops_pkg::*;
#(
    parameter int NUM_SEMS = NUM_SEMS_DEF,
    parameter int MAX_OPS  = MAX_OPS_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [KIND_W-1:0]          kind,
    input  wire logic [IDX_IN_W-1:0]        sem_index,
    input  wire logic signed [VAL_W-1:0]    sem_delta,
    input  wire logic                       no_wait,
    input  wire logic                       last_op,
    input  wire logic [VAL_W-1:0]           new_value,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [ST_W-1:0]                 status,
    output logic [VAL_W-1:0]                read_value,
    input  wire logic                       cfg_wr_en,
    input  wire logic [CFG_W-1:0]           cfg_wr_data
);

    ctrl_cmd_t cmd;
    dp_sts_t   sts;

    asemops_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    asemops_dpath #(
        .NUM_SEMS (NUM_SEMS),
        .MAX_OPS  (MAX_OPS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .kind        (kind),
        .sem_index   (sem_index),
        .sem_delta   (sem_delta),
        .no_wait     (no_wait),
        .last_op     (last_op),
        .new_value   (new_value),
        .status      (status),
        .read_value  (read_value)
    );

endmodule

`default_nettype wire

// File: sv/asemops_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module asemops_ctrl
    import asemops_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    output ctrl_cmd_t      cmd,
    input  wire dp_sts_t   sts
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic blocked;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // result slot still full: hold the item until the old beat leaves
    assign blocked = sts.has_result && out_valid_reg && !out_ready;

    always_comb
    begin
        cmd.capture = in_valid && in_ready;
        cmd.step    = (state_reg == S_EXEC) && !blocked;
        state_next  = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.capture)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (cmd.step)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.step && sts.has_result)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && blocked) |=> state_reg == S_EXEC)
        else $error("item left execute while result slot was full");

    a_result_posted: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && sts.has_result) |=> out_valid_reg)
        else $error("finished item did not post a result");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == S_EXEC && !in_ready))
        else $error("accepted item did not enter execute");

endmodule

`default_nettype wire

// File: sv/asemops_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module asemops_dpath
    import asemops_pkg::*;
#(
    parameter int NUM_SEMS = NUM_SEMS_DEF,
    parameter int MAX_OPS  = MAX_OPS_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire ctrl_cmd_t                  cmd,
    output dp_sts_t                         sts,
    input  wire logic                       cfg_wr_en,
    input  wire logic [CFG_W-1:0]           cfg_wr_data,
    input  wire logic [KIND_W-1:0]          kind,
    input  wire logic [IDX_IN_W-1:0]        sem_index,
    input  wire logic signed [VAL_W-1:0]    sem_delta,
    input  wire logic                       no_wait,
    input  wire logic                       last_op,
    input  wire logic [VAL_W-1:0]           new_value,
    output logic [ST_W-1:0]                 status,
    output logic [VAL_W-1:0]                read_value
);

    localparam int IDX_W = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int LIM_W = $clog2(NUM_SEMS + 1);
    localparam int CMP_W = (LIM_W > IDX_IN_W) ? LIM_W : IDX_IN_W;

    // Two copies per semaphore. cur_sel picks the committed copy; a touched
    // entry keeps its transaction value in the other copy.
    logic [VAL_W-1:0] mem_a [NUM_SEMS];
    logic [VAL_W-1:0] mem_b [NUM_SEMS];
    logic [NUM_SEMS-1:0] vld_a_reg, vld_a_next;
    logic [NUM_SEMS-1:0] vld_b_reg, vld_b_next;
    logic [NUM_SEMS-1:0] cur_sel_reg, cur_sel_next;
    logic [NUM_SEMS-1:0] touched_reg, touched_next;

    logic [VAL_W-1:0] rd_a_reg, rd_b_reg;

    logic [KIND_W-1:0]          kind_reg;
    logic [IDX_IN_W-1:0]        idx_reg;
    logic signed [VAL_W-1:0]    delta_reg;
    logic                       no_wait_reg;
    logic                       last_reg;
    logic [VAL_W-1:0]           nv_reg;

    logic [CFG_W-1:0]   sems_in_use_reg;
    logic               in_trans_reg, in_trans_next;
    logic [CNT_W-1:0]   op_count_reg, op_count_next;
    logic [ST_W-1:0]    pending_reg, pending_next;

    logic [ST_W-1:0]    status_reg;
    logic [VAL_W-1:0]   read_value_reg;

    logic [IDX_W-1:0]   addr;
    logic [CMP_W-1:0]   limit;
    logic               idx_ok;
    logic               cur, tch;
    logic [VAL_W-1:0]   va, vb, cur_val, sh_val;
    logic [CNT_W-1:0]   cnt;
    logic [ST_W-1:0]    pend0, pend1, pend_fin, fail_code;
    logic               too_many;
    logic [VAL_W-1:0]   mag;
    logic [VAL_W:0]     diff;
    logic               is_op, is_set, is_get;
    logic               wr_en, wr_sel_b, mark, flip;
    logic [VAL_W-1:0]   wr_val;
    logic [NUM_SEMS-1:0] hit, t1, c1;
    logic               commit, end_tr;
    logic [ST_W-1:0]    res_status;
    logic [VAL_W-1:0]   res_value;

    assign status     = status_reg;
    assign read_value = read_value_reg;

    assign addr = IDX_W'(idx_reg);

    always_comb
    begin
        if (sems_in_use_reg == '0)
            limit = CMP_W'(1);
        else if (CMP_W'(sems_in_use_reg) > CMP_W'(NUM_SEMS))
            limit = CMP_W'(NUM_SEMS);
        else
            limit = CMP_W'(sems_in_use_reg);
    end

    assign idx_ok = CMP_W'(idx_reg) < limit;

    always_comb
    begin
        for (int i = 0; i < NUM_SEMS; i++)
            hit[i] = (addr == IDX_W'(i));
    end

    always_comb
    begin
        cur     = cur_sel_reg[addr];
        tch     = touched_reg[addr];
        va      = vld_a_reg[addr] ? rd_a_reg : '0;
        vb      = vld_b_reg[addr] ? rd_b_reg : '0;
        cur_val = cur ? vb : va;
        sh_val  = (cur ^ tch) ? vb : va;

        is_op  = (kind_reg == KIND_OP);
        is_set = (kind_reg == KIND_SET);
        is_get = (kind_reg == KIND_GET);

        cnt       = in_trans_reg ? op_count_reg : '0;
        pend0     = in_trans_reg ? pending_reg : ST_OK;
        too_many  = cnt >= CNT_W'(MAX_OPS);
        pend1     = too_many ? ST_TOOMANY : pend0;
        fail_code = no_wait_reg ? ST_AGAIN : ST_BLOCK;

        mag  = ~delta_reg + 1'b1;
        diff = {1'b0, sh_val} - {1'b0, mag};

        pend_fin = pend1;
        wr_en    = 1'b0;
        wr_sel_b = 1'b0;
        wr_val   = nv_reg;
        mark     = 1'b0;
        flip     = 1'b0;

        if (is_op && pend1 == ST_OK)
        begin
            if (!idx_ok)
                pend_fin = ST_BADIDX;
            else if (delta_reg > 0)
            begin
                wr_en  = 1'b1;
                wr_val = sh_val + delta_reg;
            end
            else if (delta_reg < 0)
            begin
                if (diff[VAL_W])
                    pend_fin = fail_code;
                else
                begin
                    wr_en  = 1'b1;
                    wr_val = diff[VAL_W-1:0];
                end
            end
            else if (sh_val != '0)
                pend_fin = fail_code;
            // op writes always land in the non-committed copy
            wr_sel_b = ~cur;
            mark     = wr_en;
        end
        else if (is_set && idx_ok)
        begin
            wr_en = 1'b1;
            if (in_trans_reg && !tch)
            begin
                // keep the old value as shadow, committed copy moves over
                wr_sel_b = ~cur;
                flip     = 1'b1;
                mark     = 1'b1;
            end
            else
                wr_sel_b = cur;
        end

        t1     = touched_reg | (mark ? hit : '0);
        c1     = cur_sel_reg ^ (flip ? hit : '0);
        end_tr = is_op && last_reg;
        commit = end_tr && (pend_fin == ST_OK);
        cur_sel_next = c1 ^ (commit ? t1 : '0);
        touched_next = end_tr ? '0 : t1;
        vld_a_next   = vld_a_reg | ((wr_en && !wr_sel_b) ? hit : '0);
        vld_b_next   = vld_b_reg | ((wr_en && wr_sel_b) ? hit : '0);

        if (end_tr)
        begin
            in_trans_next = 1'b0;
            op_count_next = '0;
            pending_next  = ST_OK;
        end
        else if (is_op)
        begin
            in_trans_next = 1'b1;
            op_count_next = too_many ? cnt : cnt + 1'b1;
            pending_next  = pend_fin;
        end
        else
        begin
            in_trans_next = in_trans_reg;
            op_count_next = op_count_reg;
            pending_next  = pending_reg;
        end

        sts.has_result = end_tr || is_set || is_get;
        if (is_op)
        begin
            res_status = pend_fin;
            res_value  = '0;
        end
        else
        begin
            res_status = idx_ok ? ST_OK : ST_BADIDX;
            res_value  = (is_get && idx_ok) ? cur_val : '0;
        end
    end

    // memories: read on capture, written on step
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rd_a_reg <= mem_a[IDX_W'(sem_index)];
            rd_b_reg <= mem_b[IDX_W'(sem_index)];
        end
        if (cmd.step && wr_en && !wr_sel_b)
            mem_a[addr] <= wr_val;
        if (cmd.step && wr_en && wr_sel_b)
            mem_b[addr] <= wr_val;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg    <= kind;
            idx_reg     <= sem_index;
            delta_reg   <= sem_delta;
            no_wait_reg <= no_wait;
            last_reg    <= last_op;
            nv_reg      <= new_value;
        end
        if (cmd.step && sts.has_result)
        begin
            status_reg     <= res_status;
            read_value_reg <= res_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sems_in_use_reg <= CFG_RESET;
            in_trans_reg    <= 1'b0;
            op_count_reg    <= '0;
            pending_reg     <= ST_OK;
            vld_a_reg       <= '0;
            vld_b_reg       <= '0;
            cur_sel_reg     <= '0;
            touched_reg     <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                sems_in_use_reg <= cfg_wr_data;
            if (cmd.step)
            begin
                in_trans_reg <= in_trans_next;
                op_count_reg <= op_count_next;
                pending_reg  <= pending_next;
                vld_a_reg    <= vld_a_next;
                vld_b_reg    <= vld_b_next;
                cur_sel_reg  <= cur_sel_next;
                touched_reg  <= touched_next;
            end
        end
    end

    a_clean_outside_trans: assert property (@(posedge clk) disable iff (!rst_n)
        !in_trans_reg |-> (touched_reg == '0 && pending_reg == ST_OK))
        else $error("transaction state left over after end of transaction");

    a_op_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        op_count_reg <= CNT_W'(MAX_OPS))
        else $error("operation count above limit");

    a_count_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && is_op && !last_reg && too_many) |=> pending_reg == ST_TOOMANY)
        else $error("overflowing transaction lost its too-many outcome");

endmodule

`default_nettype wire
